[hdl/u8d_pkg.sv]
package u8d_pkg;

   localparam int MAX_RESULTS = 3;
   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam logic [15:0] REPLACEMENT_RESET = 16'hFFFD;

   typedef logic [MAX_RESULTS-1:0][15:0] code_group_type;

   // All results caused by one accepted byte, oldest in slot 0.
   typedef struct packed {
      logic [1:0]             count;
      code_group_type         code_point;
      logic [MAX_RESULTS-1:0] text_end;
   } entry_type;

endpackage

[hdl/u8d_front.sv]
module u8d_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  logic [7:0]         req_in_byte,
   output logic               req_full,
   input  logic               csr_write,
   input  logic [15:0]        csr_replacement_code,
   output logic               q_push,
   output u8d_pkg::entry_type q_entry,
   input  logic               q_full
);
   import u8d_pkg::*;

   typedef logic [2:0][7:0] window_type;

   typedef struct packed {
      logic [1:0]  used;
      logic [15:0] code;
   } decision_type;

   logic [1:0][7:0] held_ff, held_in;
   logic [1:0]      held_count_ff, held_count_in;
   logic [15:0]     repl_ff;

   window_type  window;
   logic [1:0]  n;
   logic [1:0]  pos;
   logic [1:0]  cnt;
   logic [1:0]  avail;
   logic        stop;
   logic        ending;
   logic [7:0]  b1;
   logic [7:0]  b2;
   decision_type dec;
   entry_type   entry;
   logic        accept;

   function automatic logic [7:0] pick(input window_type w, input logic [1:0] idx);
      logic [7:0] r;
      r = 8'h00;
      if (idx != 2'd3) begin
         r = w[idx];
      end
      return r;
   endfunction

   function automatic logic is_cont(input logic [7:0] b);
      return (b[7:6] == 2'b10);
   endfunction

   // Decides the sequence that starts at lead; used is zero when it must wait.
   function automatic decision_type decide(input logic [7:0] lead, input logic [7:0] c1,
                                           input logic [7:0] c2, input logic [1:0] av,
                                           input logic fin, input logic [15:0] repl);
      decision_type d;
      logic [10:0]  v2;
      logic [15:0]  v3;
      d.used = 2'd1;
      d.code = repl;
      v2 = {lead[4:0], c1[5:0]};
      v3 = {lead[3:0], c1[5:0], c2[5:0]};
      if (lead[7] == 1'b0) begin
         d.code = {8'h00, lead};
      end else if (lead[7:5] == 3'b110) begin
         if (av < 2'd2 && !fin) begin
            d.used = 2'd0;
         end else if (is_cont(c1) && v2 >= 11'h080) begin
            d.used = 2'd2;
            d.code = {5'd0, v2};
         end
      end else if (lead[7:4] == 4'b1110) begin
         if (!fin && (av < 2'd2 || (av < 2'd3 && is_cont(c1)))) begin
            d.used = 2'd0;
         end else if (is_cont(c1) && is_cont(c2) && v3 >= 16'h0800) begin
            d.used = 2'd3;
            d.code = v3;
         end
      end
      return d;
   endfunction

   assign accept   = req_push && !q_full;
   assign req_full = q_full;
   assign ending   = (req_in_byte == 8'h00);

   always_comb begin
      window = '0;
      window[0] = held_ff[0];
      window[1] = held_ff[1];
      n = held_count_ff;
      if (!ending) begin
         if (n == 2'd0) begin
            window[0] = req_in_byte;
         end else if (n == 2'd1) begin
            window[1] = req_in_byte;
         end else begin
            window[2] = req_in_byte;
         end
         n = n + 2'd1;
      end
      pos   = 2'd0;
      cnt   = 2'd0;
      stop  = 1'b0;
      entry = '0;
      avail = 2'd0;
      b1    = 8'h00;
      b2    = 8'h00;
      dec   = '0;
      // Each pass decodes one sequence; a rejected lead costs one byte and
      // the following bytes are rescanned in the next pass.
      for (int i = 0; i < MAX_RESULTS; i++) begin
         if (!stop && pos < n) begin
            avail = n - pos;
            b1 = (avail > 2'd1) ? pick(window, pos + 2'd1) : 8'h00;
            b2 = (avail > 2'd2) ? pick(window, pos + 2'd2) : 8'h00;
            dec = decide(pick(window, pos), b1, b2, avail, ending, repl_ff);
            if (dec.used == 2'd0) begin
               stop = 1'b1;
            end else begin
               entry.code_point[i] = dec.code;
               cnt = cnt + 2'd1;
               pos = pos + dec.used;
            end
         end
      end
      if (ending) begin
         if (cnt == 2'd0) begin
            entry.text_end[0] = 1'b1;
         end else if (cnt == 2'd1) begin
            entry.text_end[1] = 1'b1;
         end else begin
            entry.text_end[2] = 1'b1;
         end
         cnt = cnt + 2'd1;
         pos = n;
      end
      entry.count   = cnt;
      held_count_in = n - pos;
      held_in[0]    = pick(window, pos);
      held_in[1]    = pick(window, pos + 2'd1);
   end

   assign q_push  = accept && (cnt != 2'd0);
   assign q_entry = entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff       <= '0;
         held_count_ff <= 2'd0;
      end else if (accept) begin
         held_ff       <= held_in;
         held_count_ff <= held_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         repl_ff <= REPLACEMENT_RESET;
      end else if (csr_write) begin
         repl_ff <= csr_replacement_code;
      end
   end

endmodule

[hdl/u8d_queue.sv]
module u8d_queue #(
   parameter int DEPTH = u8d_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  u8d_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output u8d_pkg::entry_type head,
   output logic               empty
);
   import u8d_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (fill_ff == CNT_W'(DEPTH));
   assign empty   = (fill_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[hdl/u8d_back.sv]
module u8d_back (
   input  logic               clock,
   input  logic               reset,
   input  u8d_pkg::entry_type head,
   input  logic               q_empty,
   output logic               q_pop,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [15:0]        rsp_code_point,
   output logic               rsp_text_end,
   output logic               rsp_run_last
);
   import u8d_pkg::*;

   logic [1:0] slot_ff, slot_in;
   logic       last;
   logic       transfer;

   assign rsp_empty      = q_empty;
   assign last           = (slot_ff == head.count - 2'd1);
   assign transfer       = rsp_pop && !q_empty;
   assign rsp_code_point = head.code_point[slot_ff];
   assign rsp_text_end   = head.text_end[slot_ff];
   assign rsp_run_last   = last;
   assign q_pop          = transfer && last;

   always_comb begin
      slot_in = slot_ff;
      if (transfer) begin
         slot_in = last ? 2'd0 : slot_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= 2'd0;
      end else begin
         slot_ff <= slot_in;
      end
   end

endmodule

[hdl/utf8_bmp_stream_decoder_unit.sv]
// The results of a byte are registered in the result queue and offered from its head after any older entries.
// Throughput: one byte per cycle while the result queue has room; the output side delivers
// one result per cycle while rsp_pop is high, so a byte that yields k results takes k pops.
// The queue between the decoder and the output sequencer sets how far the two sides can drift.
// Reset clears the held bytes and the queue and restores the replacement code to 0xFFFD.
module utf8_bmp_stream_decoder_unit #(
   parameter int QUEUE_DEPTH = u8d_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic [7:0]  req_in_byte,
   output logic        req_full,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [15:0] rsp_code_point,
   output logic        rsp_text_end,
   output logic        rsp_run_last,
   input  logic        csr_write,
   input  logic [15:0] csr_replacement_code
);
   import u8d_pkg::*;

   logic      q_push;
   logic      q_full;
   logic      q_pop;
   logic      q_empty;
   entry_type q_entry;
   entry_type q_head;

   u8d_front front_i (
      .clock                (clock),
      .reset                (reset),
      .req_push             (req_push),
      .req_in_byte          (req_in_byte),
      .req_full             (req_full),
      .csr_write            (csr_write),
      .csr_replacement_code (csr_replacement_code),
      .q_push               (q_push),
      .q_entry              (q_entry),
      .q_full               (q_full)
   );

   u8d_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) queue_i (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head       (q_head),
      .empty      (q_empty)
   );

   u8d_back back_i (
      .clock          (clock),
      .reset          (reset),
      .head           (q_head),
      .q_empty        (q_empty),
      .q_pop          (q_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_code_point (rsp_code_point),
      .rsp_text_end   (rsp_text_end),
      .rsp_run_last   (rsp_run_last)
   );

endmodule
